>>> rtl/core/psdf_pkg.sv
// shared constants, types and helpers for the strength/density fitness core
// no dependencies
`default_nettype none
package psdf_pkg;
	localparam int POP_MAX  = 1024;
	localparam int MAX_RANK = 8;
	localparam int ADDR_W   = $clog2(POP_MAX);
	localparam int CNT_W    = $clog2(POP_MAX + 1);
	localparam int OBJ_W    = 20;
	localparam int PT_W     = 2 * OBJ_W;
	localparam int RND_W    = 14;
	localparam int SQ_W     = 41;
	localparam int RANK_W   = 4;
	localparam int KW       = $clog2(MAX_RANK + 1);
	localparam int RIDX_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int QI_W     = 10;
	localparam int STR_W    = 10;
	localparam int DEN_W    = 16;
	localparam int FIT_W    = 26;
	localparam int QDEPTH   = 2;
	localparam int PTR_W    = 1;
	localparam int LVL_W    = 2;

	localparam logic [RANK_W-1:0] RANK_RESET = 4'd6;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_QUERY = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISSING  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		req_t             kind;
		logic [OBJ_W-1:0] a;
		logic [OBJ_W-1:0] b;
		logic [QI_W-1:0]  qi;
	} cmd_t;

	// round q4.16 half-up to thousandths
	function automatic logic [RND_W-1:0] thousandths(input logic [OBJ_W-1:0] v);
		logic [29:0] p;
		p = 30'(v) * 30'd1000 + 30'd32768;
		return p[29:16];
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/pareto_strength_density_fitness_core.sv
// top level of the strength/density fitness core: rank register, front, back
// depends on psdf_pkg, psdf_front, psdf_back
//
//  channel   handshake                    payload
//  request   start / busy                 req_type, first_objective,
//                                          second_objective, query_index
//  config    neighbor_rank_we             neighbor_rank
//  result    done (one-cycle strobe)      point_index, strength, density,
//                                          fitness, status
//
// clear and load are handled in the back-end idle state; a query of an
// unloaded index goes straight to the result; the length of a full query is
// set by the one-point-per-cycle walk over the store memory read port, then 21
// square-root steps and 33 divider steps.
// reset empties the store and sets neighbor_rank to 6.
// busy rises only when the two-entry request queue is full.
`default_nettype none
module pareto_strength_density_fitness_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [19:0] first_objective,
	input  wire logic [19:0] second_objective,
	input  wire logic [9:0]  query_index,
	input  wire logic        neighbor_rank_we,
	input  wire logic [3:0]  neighbor_rank,
	output logic             done,
	output logic [9:0]       point_index,
	output logic [9:0]       strength,
	output logic [15:0]      density,
	output logic [25:0]      fitness,
	output logic [1:0]       status
);
	import psdf_pkg::*;

	logic [RANK_W-1:0] rank_q;
	logic              pop, cmd_valid;
	cmd_t              cmd;

	// neighbor rank register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rank_q <= RANK_RESET;
		else if (neighbor_rank_we)
			rank_q <= neighbor_rank;
	end

	psdf_front u_front (
		.clk, .arst_n, .start, .busy, .req_type, .first_objective,
		.second_objective, .query_index, .pop, .cmd_valid, .cmd
	);

	psdf_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .pop, .rank(rank_q), .done,
		.point_index, .strength, .density, .fitness, .status
	);
endmodule
`default_nettype wire

>>> rtl/core/psdf_front.sv
// front end: takes requests, drops unused codes, queues them for the back end
// depends on psdf_pkg
`default_nettype none
module psdf_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [1:0]       req_type,
	input  wire logic [19:0]      first_objective,
	input  wire logic [19:0]      second_objective,
	input  wire logic [9:0]       query_index,
	input  wire logic             pop,
	output logic                  cmd_valid,
	output psdf_pkg::cmd_t        cmd
);
	import psdf_pkg::*;

	cmd_t              q_mem_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              push, do_pop;

	// classify: unused request code takes no queue slot
	assign busy      = (level_q == LVL_W'(QDEPTH));
	assign push      = start && !busy && (req_t'(req_type) != REQ_NONE);
	assign cmd_valid = (level_q != '0);
	assign do_pop    = pop && cmd_valid;
	assign cmd       = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{kind: req_t'(req_type), a: first_objective,
				b: second_objective, qi: query_index};
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				level_q <= level_q + 1'b1;
			else if (do_pop && !push)
				level_q <= level_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/psdf_back.sv
// back end: point store, scan pipeline, square root and reciprocal units
// depends on psdf_pkg
`default_nettype none
module psdf_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cmd_valid,
	input  wire psdf_pkg::cmd_t           cmd,
	output logic                          pop,
	input  wire logic [psdf_pkg::RANK_W-1:0] rank,
	output logic                          done,
	output logic [9:0]                    point_index,
	output logic [9:0]                    strength,
	output logic [15:0]                   density,
	output logic [25:0]                   fitness,
	output logic [1:0]                    status
);
	import psdf_pkg::*;

	typedef enum logic [8:0] {
		B_IDLE  = 9'b000000001,
		B_RDME  = 9'b000000010,
		B_CAPME = 9'b000000100,
		B_RNDME = 9'b000001000,
		B_SCAN  = 9'b000010000,
		B_DRAIN = 9'b000100000,
		B_SQRT  = 9'b001000000,
		B_DIV   = 9'b010000000,
		B_OUT   = 9'b100000000
	} bstate_t;

	bstate_t            state_q;
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic [PT_W-1:0]    mem [POP_MAX];
	logic [PT_W-1:0]    rd_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic               we;
	logic [QI_W-1:0]    qi_q;
	logic [KW-1:0]      k_q;
	logic [OBJ_W-1:0]   me_a_q, me_b_q;
	logic [RND_W-1:0]   ra_q, rb_q;
	logic [CNT_W-1:0]   scan_i_q;
	logic [STR_W-1:0]   str_q;
	logic [SQ_W-1:0]    nsd_q [MAX_RANK];
	logic [SQ_W-1:0]    nsd_nx [MAX_RANK];
	logic [MAX_RANK-1:0] lt;
	logic [SQ_W-1:0]    sq;

	// scan pipeline
	logic               v_s1, skip_s1;
	logic               v_s2;
	logic [RND_W-1:0]   oa_s2, ob_s2;
	logic [OBJ_W-1:0]   dx_s2, dy_s2;
	logic               v_s3, dom_s3;
	logic [2*OBJ_W-1:0] dxx_s3, dyy_s3;

	// square root and divider
	logic [SQ_W:0]      sv_q, sres_q, sbit_q;
	logic [SQ_W:0]      strial;
	logic [21:0]        den_q;
	logic [21:0]        den_nx;
	logic [32:0]        num_q;
	logic [21:0]        rem_q;
	logic [22:0]        r2;
	logic               qbit;
	logic [16:0]        quo_q;
	logic [5:0]         dcnt_q;

	logic [CNT_W-1:0]   cm1;
	logic [KW-1:0]      rank_eff;
	logic [OBJ_W-1:0]   pa, pb;

	assign pop     = (state_q == B_IDLE) && cmd_valid;
	assign we      = pop && (cmd.kind == REQ_LOAD) && (count_q != CNT_W'(POP_MAX));
	assign rd_addr = (state_q == B_RDME) ? ADDR_W'(qi_q) : scan_i_q[ADDR_W-1:0];
	assign done    = (state_q == B_OUT);
	assign point_index = qi_q;
	assign pa      = rd_q[OBJ_W-1:0];
	assign pb      = rd_q[PT_W-1:OBJ_W];
	assign cm1     = count_q - 1'b1;
	assign strial  = sres_q + sbit_q;
	assign den_nx  = 22'd131072 + ((sv_q >= strial) ?
		22'((sres_q >> 1) + sbit_q) : 22'(sres_q >> 1));
	assign r2      = {rem_q, num_q[32]};
	assign qbit    = (r2 >= 23'(den_q));

	// effective rank: zero acts as one, clamp at the list depth
	always_comb begin
		if (rank == '0)
			rank_eff = KW'(1);
		else if (32'(rank) > MAX_RANK)
			rank_eff = KW'(MAX_RANK);
		else
			rank_eff = KW'(rank);
	end

	// point store
	always_ff @(posedge clk) begin
		if (we)
			mem[count_q[ADDR_W-1:0]] <= {cmd.b, cmd.a};
		rd_q <= mem[rd_addr];
	end

	// sorted insertion of the new squared distance
	always_comb begin
		sq = SQ_W'(dxx_s3) + SQ_W'(dyy_s3);
		for (int j = 0; j < MAX_RANK; j++)
			lt[j] = (sq < nsd_q[j]);
		for (int j = 0; j < MAX_RANK; j++) begin
			if (!lt[j])
				nsd_nx[j] = nsd_q[j];
			else if (j > 0 && lt[(j > 0) ? j - 1 : 0])
				nsd_nx[j] = nsd_q[(j > 0) ? j - 1 : 0];
			else
				nsd_nx[j] = sq;
		end
	end

	// pipeline datapath
	always_ff @(posedge clk) begin
		skip_s1 <= (scan_i_q[ADDR_W-1:0] == ADDR_W'(qi_q));
		oa_s2   <= thousandths(pa);
		ob_s2   <= thousandths(pb);
		dx_s2   <= (pa > me_a_q) ? pa - me_a_q : me_a_q - pa;
		dy_s2   <= (pb > me_b_q) ? pb - me_b_q : me_b_q - pb;
		dom_s3  <= (oa_s2 <= ra_q) && (ob_s2 <= rb_q) && ((oa_s2 != ra_q) || (ob_s2 != rb_q));
		dxx_s3  <= dx_s2 * dx_s2;
		dyy_s3  <= dy_s2 * dy_s2;
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == B_SCAN);
			v_s2 <= v_s1 && !skip_s1;
			v_s3 <= v_s2;
		end
	end

	// query payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				qi_q <= cmd.qi;
				str_q <= '0;
				for (int j = 0; j < MAX_RANK; j++)
					nsd_q[j] <= '1;
				k_q <= (cm1 < CNT_W'(rank_eff)) ? KW'(cm1) : rank_eff;
				strength <= '0;
				density  <= '0;
				fitness  <= '0;
				status   <= ST_MISSING;
			end
			B_CAPME: begin
				me_a_q <= rd_q[OBJ_W-1:0];
				me_b_q <= rd_q[PT_W-1:OBJ_W];
			end
			B_RNDME: begin
				ra_q <= thousandths(me_a_q);
				rb_q <= thousandths(me_b_q);
			end
			B_SCAN, B_DRAIN: begin
				if (v_s3) begin
					if (dom_s3 && str_q != '1)
						str_q <= str_q + 1'b1;
					if (k_q != '0)
						nsd_q <= nsd_nx;
				end
				sv_q   <= (k_q == '0) ? '0 : (SQ_W + 1)'(nsd_q[RIDX_W'(k_q - 1'b1)]);
				sres_q <= '0;
				sbit_q <= (SQ_W + 1)'(1) << (SQ_W - 1);
			end
			B_SQRT: begin
				if (sv_q >= strial) begin
					sv_q   <= sv_q - strial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				// numerator is 2^32 plus half the divisor
				den_q  <= den_nx;
				num_q  <= {1'b1, 11'd0, den_nx[21:1]};
				rem_q  <= '0;
				quo_q  <= '0;
				dcnt_q <= 6'd32;
			end
			B_DIV: begin
				if (qbit) begin
					rem_q <= 22'(r2 - 23'(den_q));
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= r2[21:0];
					quo_q <= {quo_q[15:0], 1'b0};
				end
				num_q  <= num_q << 1;
				dcnt_q <= dcnt_q - 1'b1;
				strength <= str_q;
				status   <= ovf_q ? ST_OVERFLOW : ST_OK;
			end
			B_OUT: begin
			end
			default: begin
			end
		endcase
		// final quotient bit lands on leaving the divider
		if (state_q == B_DIV && dcnt_q == '0) begin
			density <= {quo_q[14:0], qbit};
			fitness <= {str_q, quo_q[14:0], qbit};
		end
	end

	// control: store bookkeeping and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			scan_i_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					scan_i_q <= '0;
					if (cmd_valid) begin
						case (cmd.kind)
							REQ_CLEAR: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
							end
							REQ_LOAD: begin
								if (count_q == CNT_W'(POP_MAX))
									ovf_q <= 1'b1;
								else
									count_q <= count_q + 1'b1;
							end
							REQ_QUERY: begin
								if (CNT_W'(cmd.qi) >= count_q)
									state_q <= B_OUT;
								else
									state_q <= B_RDME;
							end
							default: begin
							end
						endcase
					end
				end
				B_RDME:  state_q <= B_CAPME;
				B_CAPME: state_q <= B_RNDME;
				B_RNDME: state_q <= B_SCAN;
				B_SCAN: begin
					scan_i_q <= scan_i_q + 1'b1;
					if (scan_i_q == cm1)
						state_q <= B_DRAIN;
				end
				B_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3)
						state_q <= B_SQRT;
				end
				B_SQRT: begin
					if (sbit_q == (SQ_W + 1)'(1))
						state_q <= B_DIV;
				end
				B_DIV: begin
					if (dcnt_q == '0)
						state_q <= B_OUT;
				end
				B_OUT:   state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/psdf_checker.sv
// port-level checks on results of the fitness core, bound to the top level
// depends on psdf_pkg and pareto_strength_density_fitness_core
`default_nettype none
module psdf_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        done,
	input wire logic [9:0]  strength,
	input wire logic [15:0] density,
	input wire logic [25:0] fitness,
	input wire logic [1:0]  status
);
	import psdf_pkg::*;

	// unloaded index reports all zero
	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_MISSING |-> fitness == '0 && density == '0 && strength == '0)
		else $error("unloaded index with nonzero result");

	// fitness packs strength above density
	a_fit_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fitness[15:0] == density && fitness[25:16] == strength)
		else $error("fitness does not match strength and density");

	// density bound and legal status
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> density <= 16'd32768 && status != 2'd3)
		else $error("density or status out of range");

	// results never come in adjacent cycles
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back results");
endmodule

bind pareto_strength_density_fitness_core psdf_props u_props (
	.clk(clk), .arst_n(arst_n), .done(done), .strength(strength),
	.density(density), .fitness(fitness), .status(status)
);
`default_nettype wire
